FILE: rtl/core/rars_pkg.sv
// ----------------------------------------------------------------------------
// rars_pkg
// Shared widths, codes and the command/status bundles between the range-sum
// tree controller and its datapath.
// ----------------------------------------------------------------------------
`default_nettype none
package rars_pkg;

	localparam int LOG_N  = 16;
	localparam int N_MAX  = 1 << LOG_N;
	localparam int NODE_W = LOG_N + 1;
	localparam int LVL_W  = $clog2(LOG_N + 1);
	localparam int VAL_W  = 31;
	localparam int POS_W  = 17;
	localparam int LEN_W  = 17;
	localparam int OPC_W  = 2;
	localparam int IDX_W  = 2;
	localparam int OPW    = VAL_W + LOG_N;

	localparam logic [OPC_W-1:0] OP_LOAD = 2'd0;
	localparam logic [OPC_W-1:0] OP_ADD  = 2'd1;
	localparam logic [OPC_W-1:0] OP_SUM  = 2'd2;
	localparam logic [OPC_W-1:0] OP_NONE = 2'd3;

	localparam logic [IDX_W-1:0] REG_MODULUS = 2'd0;
	localparam logic [IDX_W-1:0] REG_LENGTH  = 2'd1;

	localparam logic [VAL_W-1:0] MODULUS_RESET = 31'h7FFF_FFFF;
	localparam logic [LEN_W-1:0] LENGTH_RESET  = LEN_W'(N_MAX);

	typedef enum logic [1:0] {ADDR_NODE, ADDR_LEFT, ADDR_RIGHT, ADDR_CLEAR} addr_sel_t;
	typedef enum logic [1:0] {SRC_VALUE, SRC_GROW, SRC_SUM, SRC_TAG} mod_src_t;
	typedef enum logic [2:0] {CAP_NONE, CAP_VALUE, CAP_TAG, CAP_A, CAP_B} cap_t;
	typedef enum logic [1:0] {SW_VALUE, SW_APPLY, SW_PULL} sum_wsel_t;
	typedef enum logic {TW_ZERO, TW_APPLY} tag_wsel_t;
	typedef enum logic [1:0] {NAV_NONE, NAV_LEFT, NAV_RIGHT, NAV_UP} nav_t;

	typedef struct packed {
		logic      start_item;
		logic      clear_step;
		logic      mem_rd;
		addr_sel_t addr_sel;
		logic      sum_we;
		sum_wsel_t sum_wsel;
		logic      tag_we;
		tag_wsel_t tag_wsel;
		logic      mod_start;
		mod_src_t  mod_src;
		cap_t      cap;
		logic      acc_add;
		nav_t      nav;
		logic      out_load;
	} cmd_t;

	typedef struct packed {
		logic             clear_done;
		logic             mod_busy;
		logic             mod_zero;
		logic [OPC_W-1:0] op;
		logic             load_ok;
		logic             range_empty;
		logic             disjoint;
		logic             covered;
		logic             leaf;
		logic             go_right;
		logic             at_root;
		logic             is_right;
		logic             out_free;
	} sts_t;

endpackage
`default_nettype wire

FILE: rtl/core/range_add_range_sum_mod_tree.sv
// ----------------------------------------------------------------------------
// range_add_range_sum_mod_tree
// Lazy-tag binary sum tree over 65536 positions with loads, range adds and
// range sums, all modulo a configured modulus.
// ----------------------------------------------------------------------------
//  Channel  Handshake                     Payload
//  input    in_valid / in_stall           operation, first_position,
//                                         last_position, value
//  output   out_valid / out_stall         range_sum
//  config   write_enable                  register_index, write_data
//
// An item walks the tree one node at a time; every modular reduction goes
// through a bit-serial remainder unit, so an item with an empty range is the
// quickest and one that walks two full paths with pushes the slowest.
// After reset a clearing pass zeroes the tag memory, during which in_stall
// is high. A query result waits in an output register; the next item is
// taken meanwhile and only a later query waits for that transfer.
`default_nettype none
module range_add_range_sum_mod_tree (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             write_enable,
	input  wire logic [rars_pkg::IDX_W-1:0]       register_index,
	input  wire logic [rars_pkg::VAL_W-1:0]       write_data,
	input  wire logic                             in_valid,
	output logic                                  in_stall,
	input  wire logic [rars_pkg::OPC_W-1:0]       operation,
	input  wire logic [rars_pkg::POS_W-1:0]       first_position,
	input  wire logic [rars_pkg::POS_W-1:0]       last_position,
	input  wire logic [rars_pkg::VAL_W-1:0]       value,
	output logic                                  out_valid,
	input  wire logic                             out_stall,
	output logic [rars_pkg::VAL_W-1:0]            range_sum
);
	rars_pkg::cmd_t cmd;
	rars_pkg::sts_t sts;

	rars_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	rars_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.write_enable   (write_enable),
		.register_index (register_index),
		.write_data     (write_data),
		.operation      (operation),
		.first_position (first_position),
		.last_position  (last_position),
		.value          (value),
		.out_stall      (out_stall),
		.out_valid      (out_valid),
		.range_sum      (range_sum)
	);
endmodule
`default_nettype wire

FILE: rtl/core/rars_mod.sv
// ----------------------------------------------------------------------------
// rars_mod
// Bit-serial remainder unit: one restoring step per cycle over a wide operand.
// ----------------------------------------------------------------------------
`default_nettype none
module rars_mod (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	input  wire logic [rars_pkg::OPW-1:0]     operand,
	input  wire logic [rars_pkg::VAL_W-1:0]   modulus,
	output logic                              busy,
	output logic [rars_pkg::VAL_W-1:0]        result
);
	localparam int CNT_W = $clog2(rars_pkg::OPW + 1);

	logic [rars_pkg::OPW-1:0]   opd_q;
	logic [rars_pkg::VAL_W-1:0] rem_q;
	logic [CNT_W-1:0]           cnt_q;
	logic                       busy_q;
	logic [rars_pkg::VAL_W:0]   trial;
	logic [rars_pkg::VAL_W:0]   rem_d;

	always_comb begin
		trial = {rem_q, opd_q[rars_pkg::OPW-1]};
		if (trial >= {1'b0, modulus}) begin
			rem_d = trial - {1'b0, modulus};
		end else begin
			rem_d = trial;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(rars_pkg::OPW);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			opd_q <= operand;
			rem_q <= '0;
		end else if (busy_q) begin
			opd_q <= {opd_q[rars_pkg::OPW-2:0], 1'b0};
			rem_q <= rem_d[rars_pkg::VAL_W-1:0];
		end
	end

	assign busy   = busy_q;
	assign result = rem_q;
endmodule
`default_nettype wire

FILE: rtl/core/rars_dp.sv
// ----------------------------------------------------------------------------
// rars_dp
// Datapath: configuration, node memories, tree walk position, modular adds,
// remainder unit and the result register.
// ----------------------------------------------------------------------------
`default_nettype none
module rars_dp (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire rars_pkg::cmd_t                   cmd,
	output rars_pkg::sts_t                        sts,
	input  wire logic                             write_enable,
	input  wire logic [rars_pkg::IDX_W-1:0]       register_index,
	input  wire logic [rars_pkg::VAL_W-1:0]       write_data,
	input  wire logic [rars_pkg::OPC_W-1:0]       operation,
	input  wire logic [rars_pkg::POS_W-1:0]       first_position,
	input  wire logic [rars_pkg::POS_W-1:0]       last_position,
	input  wire logic [rars_pkg::VAL_W-1:0]       value,
	input  wire logic                             out_stall,
	output logic                                  out_valid,
	output logic [rars_pkg::VAL_W-1:0]            range_sum
);
	localparam int NODES = 1 << rars_pkg::NODE_W;
	localparam int LOG_N = rars_pkg::LOG_N;
	localparam int LVL_W = rars_pkg::LVL_W;
	localparam int VAL_W = rars_pkg::VAL_W;
	localparam int POS_W = rars_pkg::POS_W;

	function automatic logic [VAL_W-1:0] mod_add(input logic [VAL_W-1:0] x,
		input logic [VAL_W-1:0] y, input logic [VAL_W-1:0] m);
		logic [VAL_W:0] s;
		s = {1'b0, x} + {1'b0, y};
		if (s >= {1'b0, m}) begin
			s = s - {1'b0, m};
		end
		return s[VAL_W-1:0];
	endfunction

	logic [VAL_W-1:0]             mod_q;
	logic [rars_pkg::LEN_W-1:0]   len_q;
	logic [rars_pkg::OPC_W-1:0]   op_q;
	logic [POS_W-1:0]             first_q, last_q;
	logic [VAL_W-1:0]             raw_val_q, v_q, t_q, a_q, b_q, acc_q;
	logic [rars_pkg::NODE_W-1:0]  node_q, clr_q, addr;
	logic [LVL_W-1:0]             level_q;
	logic                         out_valid_q;
	logic [VAL_W-1:0]             range_sum_q;
	logic [VAL_W-1:0]             sum_mem [NODES];
	logic [VAL_W-1:0]             tag_mem [NODES];
	logic [VAL_W-1:0]             rd_sum_q, rd_tag_q;
	logic [VAL_W-1:0]             m_eff, apply_val, sum_wdata, tag_wdata, mod_res;
	logic [rars_pkg::LEN_W-1:0]   n_eff;
	logic [POS_W-1:0]             first_c, last_c;
	logic [LOG_N-1:0]             first0, last0, lo0, hi0, span_m1, pos_sh;
	logic [rars_pkg::NODE_W-1:0]  node_sh;
	logic [LVL_W-1:0]             shamt, shamt_r, grow_k;
	logic [rars_pkg::OPW-1:0]     mod_opd;
	logic                         mod_busy;

	assign m_eff = (mod_q < VAL_W'(2)) ? VAL_W'(2) : mod_q;
	always_comb begin
		if (len_q == '0) begin
			n_eff = rars_pkg::LEN_W'(1);
		end else if (len_q > rars_pkg::LEN_W'(rars_pkg::N_MAX)) begin
			n_eff = rars_pkg::LEN_W'(rars_pkg::N_MAX);
		end else begin
			n_eff = len_q;
		end
	end

	assign first_c = (first_q == '0) ? POS_W'(1) : first_q;
	assign last_c  = (last_q > POS_W'(n_eff)) ? POS_W'(n_eff) : last_q;
	assign first0  = LOG_N'(first_c - POS_W'(1));
	assign last0   = LOG_N'(last_c - POS_W'(1));

	// Span of the current node in zero-based positions.
	assign shamt   = LVL_W'(LOG_N) - level_q;
	assign shamt_r = LVL_W'(LOG_N - 1) - level_q;
	assign node_sh = node_q << shamt;
	assign lo0     = node_sh[LOG_N-1:0];
	assign span_m1 = {LOG_N{1'b1}} >> level_q;
	assign hi0     = lo0 | span_m1;
	assign pos_sh  = first0 >> shamt_r;

	always_comb begin
		case (cmd.addr_sel)
			rars_pkg::ADDR_NODE:  addr = node_q;
			rars_pkg::ADDR_LEFT:  addr = {node_q[rars_pkg::NODE_W-2:0], 1'b0};
			rars_pkg::ADDR_RIGHT: addr = {node_q[rars_pkg::NODE_W-2:0], 1'b1};
			default:              addr = clr_q;
		endcase
	end

	// A tag applied to the node itself carries the item value, one applied
	// to a child carries the tag pushed down from its parent.
	assign apply_val = (cmd.addr_sel == rars_pkg::ADDR_NODE) ? v_q : t_q;
	assign grow_k    = (cmd.addr_sel == rars_pkg::ADDR_NODE) ? shamt : shamt_r;

	always_comb begin
		case (cmd.mod_src)
			rars_pkg::SRC_VALUE: mod_opd = rars_pkg::OPW'(raw_val_q);
			rars_pkg::SRC_GROW:  mod_opd = rars_pkg::OPW'(apply_val) << grow_k;
			rars_pkg::SRC_SUM:   mod_opd = rars_pkg::OPW'(rd_sum_q);
			default:             mod_opd = rars_pkg::OPW'(rd_tag_q);
		endcase
	end

	rars_mod u_mod (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cmd.mod_start),
		.operand (mod_opd),
		.modulus (m_eff),
		.busy    (mod_busy),
		.result  (mod_res)
	);

	always_comb begin
		case (cmd.sum_wsel)
			rars_pkg::SW_VALUE: sum_wdata = v_q;
			rars_pkg::SW_APPLY: sum_wdata = mod_add(b_q, a_q, m_eff);
			default:            sum_wdata = mod_add(a_q, mod_res, m_eff);
		endcase
		if (cmd.tag_wsel == rars_pkg::TW_APPLY) begin
			tag_wdata = mod_add(mod_res, apply_val, m_eff);
		end else begin
			tag_wdata = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.sum_we) begin
			sum_mem[addr] <= sum_wdata;
		end
		if (cmd.mem_rd) begin
			rd_sum_q <= sum_mem[addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.tag_we) begin
			tag_mem[addr] <= tag_wdata;
		end
		if (cmd.mem_rd) begin
			rd_tag_q <= tag_mem[addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mod_q       <= rars_pkg::MODULUS_RESET;
			len_q       <= rars_pkg::LENGTH_RESET;
			clr_q       <= '0;
			node_q      <= rars_pkg::NODE_W'(1);
			level_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (write_enable && register_index == rars_pkg::REG_MODULUS) begin
				mod_q <= write_data;
			end
			if (write_enable && register_index == rars_pkg::REG_LENGTH) begin
				len_q <= write_data[rars_pkg::LEN_W-1:0];
			end
			if (cmd.clear_step) begin
				clr_q <= clr_q + 1'b1;
			end
			if (cmd.start_item) begin
				node_q  <= rars_pkg::NODE_W'(1);
				level_q <= '0;
			end else begin
				case (cmd.nav)
					rars_pkg::NAV_LEFT: begin
						node_q  <= {node_q[rars_pkg::NODE_W-2:0], 1'b0};
						level_q <= level_q + 1'b1;
					end
					rars_pkg::NAV_RIGHT: begin
						node_q  <= {node_q[rars_pkg::NODE_W-2:0], 1'b1};
						level_q <= level_q + 1'b1;
					end
					rars_pkg::NAV_UP: begin
						node_q  <= node_q >> 1;
						level_q <= level_q - 1'b1;
					end
					default: begin
					end
				endcase
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start_item) begin
			op_q      <= operation;
			first_q   <= first_position;
			last_q    <= last_position;
			raw_val_q <= value;
			acc_q     <= '0;
		end
		if (cmd.acc_add) begin
			acc_q <= mod_add(acc_q, mod_res, m_eff);
		end
		case (cmd.cap)
			rars_pkg::CAP_VALUE: v_q <= mod_res;
			rars_pkg::CAP_TAG:   t_q <= mod_res;
			rars_pkg::CAP_A:     a_q <= mod_res;
			rars_pkg::CAP_B:     b_q <= mod_res;
			default: begin
			end
		endcase
		if (cmd.out_load) begin
			range_sum_q <= acc_q;
		end
	end

	always_comb begin
		sts.clear_done  = &clr_q;
		sts.mod_busy    = mod_busy;
		sts.mod_zero    = (mod_res == '0);
		sts.op          = op_q;
		sts.load_ok     = (first_q != '0) && (first_q <= POS_W'(n_eff));
		sts.range_empty = (first_c > last_c);
		sts.disjoint    = (last0 < lo0) || (first0 > hi0);
		sts.covered     = (first0 <= lo0) && (hi0 <= last0);
		sts.leaf        = (level_q == LVL_W'(LOG_N));
		sts.go_right    = pos_sh[0];
		sts.at_root     = (level_q == '0);
		sts.is_right    = node_q[0];
		sts.out_free    = !out_valid_q || !out_stall;
	end

	assign out_valid = out_valid_q;
	assign range_sum = range_sum_q;
endmodule
`default_nettype wire

FILE: rtl/core/rars_ctrl.sv
// ----------------------------------------------------------------------------
// rars_ctrl
// Controller: clearing pass, depth-first tree walk without a stack, tag push,
// tag apply and sum pull sequences.
// ----------------------------------------------------------------------------
`default_nettype none
module rars_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_stall,
	input  wire rars_pkg::sts_t sts,
	output rars_pkg::cmd_t      cmd
);
	typedef enum logic [26:0] {
		S_CLR   = 27'd1 << 0,  S_IDLE  = 27'd1 << 1,  S_VM    = 27'd1 << 2,
		S_VW    = 27'd1 << 3,  S_ENTER = 27'd1 << 4,  S_PD_RD = 27'd1 << 5,
		S_PD_M  = 27'd1 << 6,  S_PD_W  = 27'd1 << 7,  S_DESC  = 27'd1 << 8,
		S_AP_RD = 27'd1 << 9,  S_AP_G  = 27'd1 << 10, S_AP_W1 = 27'd1 << 11,
		S_AP_W2 = 27'd1 << 12, S_AP_W3 = 27'd1 << 13, S_SQ_RD = 27'd1 << 14,
		S_SQ_M  = 27'd1 << 15, S_SQ_W  = 27'd1 << 16, S_LD_WR = 27'd1 << 17,
		S_RET   = 27'd1 << 18, S_POST  = 27'd1 << 19, S_PU_RL = 27'd1 << 20,
		S_PU_ML = 27'd1 << 21, S_PU_WL = 27'd1 << 22, S_PU_RR = 27'd1 << 23,
		S_PU_MR = 27'd1 << 24, S_PU_WR = 27'd1 << 25, S_DONE  = 27'd1 << 26
	} state_t;

	state_t                  state_q, state_d;
	rars_pkg::addr_sel_t     side_q, side_d;
	logic                    from_right_q, from_right_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLR;
			side_q       <= rars_pkg::ADDR_NODE;
			from_right_q <= 1'b0;
		end else begin
			state_q      <= state_d;
			side_q       <= side_d;
			from_right_q <= from_right_d;
		end
	end

	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		state_d      = state_q;
		side_d       = side_q;
		from_right_d = from_right_q;
		cmd          = '0;
		cmd.addr_sel = rars_pkg::ADDR_NODE;
		case (state_q)
			S_CLR: begin
				cmd.addr_sel   = rars_pkg::ADDR_CLEAR;
				cmd.tag_we     = 1'b1;
				cmd.tag_wsel   = rars_pkg::TW_ZERO;
				cmd.clear_step = 1'b1;
				if (sts.clear_done) state_d = S_IDLE;
			end
			S_IDLE: begin
				cmd.start_item = in_valid;
				if (in_valid) state_d = S_VM;
			end
			S_VM: begin
				cmd.mod_start = 1'b1;
				cmd.mod_src   = rars_pkg::SRC_VALUE;
				state_d       = S_VW;
			end
			S_VW: begin
				if (!sts.mod_busy) begin
					cmd.cap = rars_pkg::CAP_VALUE;
					case (sts.op)
						rars_pkg::OP_LOAD: state_d = sts.load_ok ? S_ENTER : S_IDLE;
						rars_pkg::OP_ADD:  state_d = sts.range_empty ? S_IDLE : S_ENTER;
						rars_pkg::OP_SUM:  state_d = sts.range_empty ? S_DONE : S_ENTER;
						default:           state_d = S_IDLE;
					endcase
				end
			end
			S_ENTER: begin
				case (sts.op)
					rars_pkg::OP_LOAD: state_d = sts.leaf ? S_LD_WR : S_PD_RD;
					rars_pkg::OP_ADD: begin
						if (sts.disjoint) begin
							state_d = S_RET;
						end else if (sts.covered) begin
							side_d  = rars_pkg::ADDR_NODE;
							state_d = S_AP_RD;
						end else begin
							state_d = S_PD_RD;
						end
					end
					rars_pkg::OP_SUM: begin
						if (sts.disjoint) state_d = S_RET;
						else if (sts.covered) state_d = S_SQ_RD;
						else state_d = S_PD_RD;
					end
					default: state_d = S_RET;
				endcase
			end
			S_PD_RD: begin
				cmd.mem_rd = 1'b1;
				state_d    = S_PD_M;
			end
			S_PD_M: begin
				cmd.mod_start = 1'b1;
				cmd.mod_src   = rars_pkg::SRC_TAG;
				state_d       = S_PD_W;
			end
			S_PD_W: begin
				if (!sts.mod_busy) begin
					cmd.cap      = rars_pkg::CAP_TAG;
					cmd.tag_we   = 1'b1;
					cmd.tag_wsel = rars_pkg::TW_ZERO;
					if (sts.mod_zero) begin
						state_d = S_DESC;
					end else begin
						side_d  = rars_pkg::ADDR_LEFT;
						state_d = S_AP_RD;
					end
				end
			end
			S_AP_RD: begin
				cmd.addr_sel = side_q;
				cmd.mem_rd   = 1'b1;
				state_d      = S_AP_G;
			end
			S_AP_G: begin
				cmd.addr_sel  = side_q;
				cmd.mod_start = 1'b1;
				cmd.mod_src   = rars_pkg::SRC_GROW;
				state_d       = S_AP_W1;
			end
			S_AP_W1: begin
				cmd.addr_sel = side_q;
				if (!sts.mod_busy) begin
					cmd.cap       = rars_pkg::CAP_A;
					cmd.mod_start = 1'b1;
					cmd.mod_src   = rars_pkg::SRC_SUM;
					state_d       = S_AP_W2;
				end
			end
			S_AP_W2: begin
				cmd.addr_sel = side_q;
				if (!sts.mod_busy) begin
					cmd.cap       = rars_pkg::CAP_B;
					cmd.mod_start = 1'b1;
					cmd.mod_src   = rars_pkg::SRC_TAG;
					state_d       = S_AP_W3;
				end
			end
			S_AP_W3: begin
				cmd.addr_sel = side_q;
				if (!sts.mod_busy) begin
					cmd.sum_we   = 1'b1;
					cmd.sum_wsel = rars_pkg::SW_APPLY;
					cmd.tag_we   = 1'b1;
					cmd.tag_wsel = rars_pkg::TW_APPLY;
					case (side_q)
						rars_pkg::ADDR_LEFT: begin
							side_d  = rars_pkg::ADDR_RIGHT;
							state_d = S_AP_RD;
						end
						rars_pkg::ADDR_RIGHT: state_d = S_DESC;
						default:              state_d = S_RET;
					endcase
				end
			end
			S_DESC: begin
				if (sts.op == rars_pkg::OP_LOAD && sts.go_right) begin
					cmd.nav = rars_pkg::NAV_RIGHT;
				end else begin
					cmd.nav = rars_pkg::NAV_LEFT;
				end
				state_d = S_ENTER;
			end
			S_SQ_RD: begin
				cmd.mem_rd = 1'b1;
				state_d    = S_SQ_M;
			end
			S_SQ_M: begin
				cmd.mod_start = 1'b1;
				cmd.mod_src   = rars_pkg::SRC_SUM;
				state_d       = S_SQ_W;
			end
			S_SQ_W: begin
				if (!sts.mod_busy) begin
					cmd.acc_add = 1'b1;
					state_d     = S_RET;
				end
			end
			S_LD_WR: begin
				cmd.sum_we   = 1'b1;
				cmd.sum_wsel = rars_pkg::SW_VALUE;
				cmd.tag_we   = 1'b1;
				cmd.tag_wsel = rars_pkg::TW_ZERO;
				state_d      = S_RET;
			end
			S_RET: begin
				if (sts.at_root) begin
					state_d = (sts.op == rars_pkg::OP_SUM) ? S_DONE : S_IDLE;
				end else begin
					// The parity of the node index tells which child we leave.
					from_right_d = sts.is_right;
					cmd.nav      = rars_pkg::NAV_UP;
					state_d      = S_POST;
				end
			end
			S_POST: begin
				case (sts.op)
					rars_pkg::OP_LOAD: state_d = S_PU_RL;
					rars_pkg::OP_ADD: begin
						if (from_right_q) begin
							state_d = S_PU_RL;
						end else begin
							cmd.nav = rars_pkg::NAV_RIGHT;
							state_d = S_ENTER;
						end
					end
					rars_pkg::OP_SUM: begin
						if (from_right_q) begin
							state_d = S_RET;
						end else begin
							cmd.nav = rars_pkg::NAV_RIGHT;
							state_d = S_ENTER;
						end
					end
					default: state_d = S_RET;
				endcase
			end
			S_PU_RL: begin
				cmd.addr_sel = rars_pkg::ADDR_LEFT;
				cmd.mem_rd   = 1'b1;
				state_d      = S_PU_ML;
			end
			S_PU_ML: begin
				cmd.mod_start = 1'b1;
				cmd.mod_src   = rars_pkg::SRC_SUM;
				state_d       = S_PU_WL;
			end
			S_PU_WL: begin
				if (!sts.mod_busy) begin
					cmd.cap = rars_pkg::CAP_A;
					state_d = S_PU_RR;
				end
			end
			S_PU_RR: begin
				cmd.addr_sel = rars_pkg::ADDR_RIGHT;
				cmd.mem_rd   = 1'b1;
				state_d      = S_PU_MR;
			end
			S_PU_MR: begin
				cmd.mod_start = 1'b1;
				cmd.mod_src   = rars_pkg::SRC_SUM;
				state_d       = S_PU_WR;
			end
			S_PU_WR: begin
				if (!sts.mod_busy) begin
					cmd.sum_we   = 1'b1;
					cmd.sum_wsel = rars_pkg::SW_PULL;
					state_d      = S_RET;
				end
			end
			S_DONE: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end
endmodule
`default_nettype wire

FILE: bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the modular range-add / range-sum tree. A shadow
// lazy tree predicts every query sum. Bursty input and a patterned output
// stall are applied, over several modulus and length settings.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_top;
	localparam int N_MAX = rars_pkg::N_MAX;
	localparam int OPC_W = rars_pkg::OPC_W;
	localparam int POS_W = rars_pkg::POS_W;
	localparam int VAL_W = rars_pkg::VAL_W;
	localparam int LEN_W = rars_pkg::LEN_W;
	localparam int IDX_W = rars_pkg::IDX_W;

	localparam int SLOTS = 4 * N_MAX;
	localparam int WATCHDOG_LIMIT = 600000;

	typedef struct packed {
		logic [OPC_W-1:0] op;
		logic [POS_W-1:0] first;
		logic [POS_W-1:0] last;
		logic [VAL_W-1:0] val;
	} tree_cmd_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic write_enable = 1'b0;
	logic [IDX_W-1:0] register_index = '0;
	logic [VAL_W-1:0] write_data = '0;
	logic in_valid;
	logic in_stall;
	logic [OPC_W-1:0] operation;
	logic [POS_W-1:0] first_position;
	logic [POS_W-1:0] last_position;
	logic [VAL_W-1:0] value;
	logic out_valid;
	logic out_stall;
	logic [VAL_W-1:0] range_sum;

	range_add_range_sum_mod_tree i_dut (.*);

	always #5 clk = ~clk;

	tree_cmd_t cmd_q[$];
	logic [VAL_W-1:0] sum_expect_q[$];
	int mismatches = 0;
	int results_seen = 0;

	// Shadow tree and configuration.
	logic [VAL_W-1:0] shadow_sum [0:SLOTS-1];
	logic [VAL_W-1:0] shadow_tag [0:SLOTS-1];
	logic [VAL_W-1:0] shadow_mod = rars_pkg::MODULUS_RESET;
	logic [LEN_W-1:0] shadow_len = rars_pkg::LENGTH_RESET;

	// Positions that the stimulus has loaded so far.
	bit gen_loaded [0:N_MAX];
	longint unsigned gen_len = N_MAX;

	initial begin
		for (int i = 0; i < SLOTS; i++) begin
			shadow_sum[i] = '0;
			shadow_tag[i] = '0;
		end
		for (int i = 0; i <= N_MAX; i++) gen_loaded[i] = 1'b0;
	end

	function automatic longint unsigned eff_mod();
		return (shadow_mod < 2) ? 2 : shadow_mod;
	endfunction

	function automatic longint unsigned eff_len(longint unsigned n);
		if (n < 1) return 1;
		if (n > N_MAX) return N_MAX;
		return n;
	endfunction

	function automatic void tag_node(longint unsigned nd, longint unsigned lo,
			longint unsigned hi, longint unsigned v, longint unsigned m);
		longint unsigned grow;
		grow = (v * (hi - lo + 1)) % m;
		shadow_sum[nd] = VAL_W'(((shadow_sum[nd] % m) + grow) % m);
		shadow_tag[nd] = VAL_W'(((shadow_tag[nd] % m) + v) % m);
	endfunction

	function automatic void push_tag(longint unsigned nd, longint unsigned lo,
			longint unsigned hi, longint unsigned m);
		longint unsigned mid, t;
		mid = (lo + hi) >> 1;
		t = shadow_tag[nd] % m;
		if (t != 0) begin
			tag_node(2 * nd, lo, mid, t, m);
			tag_node(2 * nd + 1, mid + 1, hi, t, m);
		end
		shadow_tag[nd] = '0;
	endfunction

	function automatic void pull_sum(longint unsigned nd, longint unsigned m);
		shadow_sum[nd] = VAL_W'(((shadow_sum[2 * nd] % m) +
			(shadow_sum[2 * nd + 1] % m)) % m);
	endfunction

	function automatic void tree_add(longint unsigned nd, longint unsigned lo,
			longint unsigned hi, longint unsigned a, longint unsigned b,
			longint unsigned v, longint unsigned m);
		longint unsigned mid;
		if (b < lo || a > hi) return;
		if (a <= lo && hi <= b) begin
			tag_node(nd, lo, hi, v, m);
			return;
		end
		push_tag(nd, lo, hi, m);
		mid = (lo + hi) >> 1;
		tree_add(2 * nd, lo, mid, a, b, v, m);
		tree_add(2 * nd + 1, mid + 1, hi, a, b, v, m);
		pull_sum(nd, m);
	endfunction

	function automatic longint unsigned tree_sum(longint unsigned nd,
			longint unsigned lo, longint unsigned hi, longint unsigned a,
			longint unsigned b, longint unsigned m);
		longint unsigned mid, s;
		if (b < lo || a > hi) return 0;
		if (a <= lo && hi <= b) return shadow_sum[nd] % m;
		push_tag(nd, lo, hi, m);
		mid = (lo + hi) >> 1;
		s = tree_sum(2 * nd, lo, mid, a, b, m);
		s = (s + tree_sum(2 * nd + 1, mid + 1, hi, a, b, m)) % m;
		return s;
	endfunction

	function automatic void tree_set(longint unsigned nd, longint unsigned lo,
			longint unsigned hi, longint unsigned pos, longint unsigned v,
			longint unsigned m);
		longint unsigned mid;
		if (lo == hi) begin
			shadow_sum[nd] = VAL_W'(v);
			shadow_tag[nd] = '0;
			return;
		end
		push_tag(nd, lo, hi, m);
		mid = (lo + hi) >> 1;
		if (pos <= mid) tree_set(2 * nd, lo, mid, pos, v, m);
		else tree_set(2 * nd + 1, mid + 1, hi, pos, v, m);
		pull_sum(nd, m);
	endfunction

	// Applies one accepted item to the shadow tree and queues any query sum.
	function automatic void predict_item(tree_cmd_t c);
		longint unsigned m, n, v, a, b;
		logic [VAL_W-1:0] want;
		m = eff_mod();
		n = eff_len(shadow_len);
		v = c.val % m;
		a = c.first;
		b = c.last;
		if (c.op == rars_pkg::OP_LOAD) begin
			if (a >= 1 && a <= n) tree_set(1, 1, N_MAX, a, v, m);
			return;
		end
		if (a < 1) a = 1;
		if (b > n) b = n;
		if (c.op == rars_pkg::OP_ADD) begin
			if (a <= b) tree_add(1, 1, N_MAX, a, b, v, m);
		end else if (c.op == rars_pkg::OP_SUM) begin
			want = '0;
			if (a <= b) want = VAL_W'(tree_sum(1, 1, N_MAX, a, b, m));
			sum_expect_q.insert(sum_expect_q.size(), want);
		end
	endfunction

	// True when the clipped range is empty or every position in it was loaded.
	function automatic bit range_loaded(longint unsigned f, longint unsigned l);
		if (f < 1) f = 1;
		if (l > gen_len) l = gen_len;
		for (longint unsigned p = f; p <= l; p++)
			if (!gen_loaded[p]) return 1'b0;
		return 1'b1;
	endfunction

	task automatic queue_cmd(logic [OPC_W-1:0] op, longint unsigned f,
			longint unsigned l, logic [VAL_W-1:0] v);
		tree_cmd_t c;
		c.op = op;
		c.first = POS_W'(f);
		c.last = POS_W'(l);
		c.val = v;
		if (op == rars_pkg::OP_LOAD && c.first >= 1 && c.first <= gen_len)
			gen_loaded[c.first] = 1'b1;
		cmd_q.insert(cmd_q.size(), c);
	endtask

	// Range command that never touches an unloaded position.
	task automatic queue_range(logic [OPC_W-1:0] op);
		longint unsigned f, l, lim;
		int pick;
		bit ok;
		ok = 1'b0;
		lim = (gen_len < 64) ? gen_len : 64;
		for (int t = 0; t < 8 && !ok; t++) begin
			pick = $urandom_range(0, 99);
			if (pick < 8) begin
				f = $urandom_range(0, (1 << POS_W) - 1);
				l = $urandom_range(0, (1 << POS_W) - 1);
			end else if (pick < 18) begin
				f = $urandom_range(0, 2);
				l = (1 << POS_W) - 1 - $urandom_range(0, 1);
			end else if (pick < 28 && gen_len > 4) begin
				f = gen_len - $urandom_range(0, 3);
				l = gen_len - $urandom_range(0, 1);
			end else begin
				f = $urandom_range(1, 32'(lim));
				l = $urandom_range(32'(f), 32'(lim));
			end
			ok = range_loaded(f, l);
		end
		if (!ok) begin
			f = 3;
			l = 2;
		end
		queue_cmd(op, f, l, VAL_W'($urandom()));
	endtask

	// Waits until nothing is queued, offered, in the block or owed as a result.
	task automatic wait_drained();
		while (cmd_q.size() != 0 || in_valid || in_stall || sum_expect_q.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_reg(logic [IDX_W-1:0] idx, logic [VAL_W-1:0] data);
		@(posedge clk);
		write_enable <= 1'b1;
		register_index <= idx;
		write_data <= data;
		@(posedge clk);
		write_enable <= 1'b0;
		if (idx == rars_pkg::REG_MODULUS) shadow_mod = data;
		else if (idx == rars_pkg::REG_LENGTH) shadow_len = LEN_W'(data);
	endtask

	// Stimulus.
	initial begin
		longint unsigned set_mod [0:7];
		logic [VAL_W-1:0] set_len [0:7];
		int pick;
		longint unsigned lim;
		set_mod = '{2147483647, 2, 7, 1000003, 0, 12345, 2147483647, 65521};
		set_len = '{65536, 1, 16, 64, 0, 131071, 65536, 37};

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: reset configuration, loads at both ends, clipping and odd items.
		for (int p = 1; p <= 8; p++) queue_cmd(rars_pkg::OP_LOAD, p, 0, VAL_W'($urandom()));
		queue_cmd(rars_pkg::OP_LOAD, 65536, 131071, 31'h7FFF_FFFF);
		queue_cmd(rars_pkg::OP_LOAD, 65535, 0, 31'h7FFF_FFFE);
		queue_cmd(rars_pkg::OP_LOAD, 0, 5, 31'h1234_5678);
		queue_cmd(rars_pkg::OP_LOAD, 131071, 1, 31'h5555_5555);
		queue_cmd(rars_pkg::OP_NONE, 1, 8, 31'h2AAA_AAAA);
		queue_cmd(rars_pkg::OP_SUM, 0, 8, 0);
		queue_cmd(rars_pkg::OP_ADD, 0, 8, 31'h7FFF_FFFF);
		queue_cmd(rars_pkg::OP_SUM, 1, 1, 31'h7FFF_FFFF);
		queue_cmd(rars_pkg::OP_SUM, 65535, 131071, 0);
		queue_cmd(rars_pkg::OP_ADD, 65535, 131071, 31'h4000_0000);
		queue_cmd(rars_pkg::OP_SUM, 65536, 65536, 0);
		queue_cmd(rars_pkg::OP_ADD, 6, 3, 31'h0000_0001);
		queue_cmd(rars_pkg::OP_SUM, 6, 3, 0);
		queue_cmd(rars_pkg::OP_SUM, 2, 7, 0);
		queue_cmd(rars_pkg::OP_SUM, 65536, 131071, 0);

		for (int ph = 0; ph < 8; ph++) begin
			wait_drained();
			write_reg(rars_pkg::REG_MODULUS, VAL_W'(set_mod[ph]));
			write_reg(rars_pkg::REG_LENGTH, set_len[ph]);
			gen_len = eff_len(LEN_W'(set_len[ph]));
			lim = (gen_len < 40) ? gen_len : 40;
			for (longint unsigned p = 1; p <= lim; p++)
				queue_cmd(rars_pkg::OP_LOAD, p, 0, VAL_W'($urandom()));
			for (int k = 0; k < 145; k++) begin
				pick = $urandom_range(0, 99);
				if (pick < 12)
					queue_cmd(rars_pkg::OP_LOAD, $urandom_range(1, 32'(lim)), $urandom(),
						VAL_W'($urandom()));
				else if (pick < 50) queue_range(rars_pkg::OP_ADD);
				else if (pick < 94) queue_range(rars_pkg::OP_SUM);
				else if (pick < 97)
					queue_cmd(rars_pkg::OP_NONE, $urandom(), $urandom(), VAL_W'($urandom()));
				else
					queue_cmd(rars_pkg::OP_LOAD, gen_len + $urandom_range(1, 3), 0,
						VAL_W'($urandom()));
			end
		end

		wait_drained();
		if (mismatches == 0 && sum_expect_q.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

	// Driver: bursts of transfers with idle gaps in between.
	int burst_left;
	int gap_left;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			burst_left <= 0;
			gap_left <= 0;
		end else if (!in_valid || !in_stall) begin
			if (gap_left > 0) begin
				gap_left <= gap_left - 1;
				in_valid <= 1'b0;
			end else if (cmd_q.size() != 0) begin
				tree_cmd_t c;
				c = cmd_q.pop_front();
				in_valid <= 1'b1;
				operation <= c.op;
				first_position <= c.first;
				last_position <= c.last;
				value <= c.val;
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 20);
					gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
				end else begin
					burst_left <= burst_left - 1;
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver stall pattern, with one long hold-off once results are flowing.
	int stall_mode = 0;
	int mode_left = 0;
	int hold_left = 0;
	bit hold_done = 1'b0;
	initial out_stall = 1'b0;
	always @(posedge clk) begin
		if (!hold_done && results_seen == 150) begin
			hold_done <= 1'b1;
			hold_left <= 40000;
			out_stall <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_stall <= (hold_left > 1);
		end else begin
			if (mode_left == 0) begin
				stall_mode <= $urandom_range(0, 2);
				mode_left <= $urandom_range(50, 3000);
			end else begin
				mode_left <= mode_left - 1;
			end
			case (stall_mode)
				0: out_stall <= 1'b0;
				1: out_stall <= 1'($urandom_range(0, 1));
				default: out_stall <= ($urandom_range(0, 9) < 8);
			endcase
		end
	end

	// Monitor: predicts on every input transfer, checks every output transfer.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				predict_item('{operation, first_position, last_position, value});
			if (out_valid && !out_stall) begin
				results_seen <= results_seen + 1;
				if (sum_expect_q.size() == 0) begin
					mismatches <= mismatches + 1;
					if (mismatches < 10) $display("unexpected range_sum %0d", range_sum);
				end else begin
					logic [VAL_W-1:0] want;
					want = sum_expect_q.pop_front();
					if (range_sum !== want) begin
						mismatches <= mismatches + 1;
						if (mismatches < 10)
							$display("range_sum mismatch: expected %0d, got %0d", want, range_sum);
					end
				end
			end
		end
	end

	// Watchdog on cycles without any transfer.
	int quiet_cycles = 0;
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

endmodule
`default_nettype wire

FILE: sim.f
rtl/core/rars_pkg.sv
rtl/core/rars_mod.sv
rtl/core/rars_dp.sv
rtl/core/rars_ctrl.sv
rtl/core/range_add_range_sum_mod_tree.sv
bench/tb_top.sv
